[sv/dvt_pkg.sv]
// package: widths, constants, codes and helpers for the digipot trim block
`default_nettype none

package dvt_pkg;

    // wiper and trim window
    localparam int WIPER_BITS     = 8;
    localparam int TRIM_WINDOW    = 10;
    localparam int SETPOINT_SPLIT = 5632;
    localparam int WIPER_MAX      = (1 << WIPER_BITS) - 1;
    localparam int WIN_BITS       = WIPER_BITS + 1;
    localparam int BIT_CNT_W      = $clog2(WIPER_BITS);
    localparam int CODE_OUT_W     = 8;

    // field widths
    localparam int OPCODE_W = 2;
    localparam int VOLT_W   = 16;
    localparam int COEF_W   = 32;

    // coefficient store and register port
    localparam int NUM_COEF = 8;
    localparam int COEF_AW  = $clog2(NUM_COEF);
    localparam int APB_AW   = COEF_AW + 2;
    localparam int APB_DW   = 32;

    // polynomial datapath
    localparam int FRAC_BITS = 16;
    localparam int PROD_SH   = 8;
    localparam int ACC_W     = 58;
    localparam int PROD_W    = ACC_W + PROD_SH;
    localparam int MUL_CNT_W = $clog2(VOLT_W);
    localparam int SAT_BIT   = 46;

    localparam logic signed [ACC_W-1:0] ACC_LIMIT = ACC_W'(1) << SAT_BIT;
    localparam logic signed [ACC_W-1:0] ACC_NEG   = -ACC_LIMIT;
    localparam logic signed [ACC_W-1:0] CODE_TOP  = ACC_W'(WIPER_MAX) << FRAC_BITS;
    localparam logic signed [ACC_W-1:0] CODE_ONE  = ACC_W'(1) << FRAC_BITS;

    // raise threshold: measured*100 < reference*99
    localparam int RATIO_W        = VOLT_W + 7;
    localparam int RAISE_MUL_MEAS = 100;
    localparam int RAISE_MUL_REF  = 99;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SET    = 2'd0,
        OP_RAISE  = 2'd1,
        OP_LOWER  = 2'd2,
        OP_RESEND = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        CI_CUBIC  = 2'd0,
        CI_SQUARE = 2'd1,
        CI_LINEAR = 2'd2,
        CI_OFFSET = 2'd3
    } t_coef_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_INIT,
        ST_PREP,
        ST_MUL,
        ST_ACC,
        ST_CODE,
        ST_WIN,
        ST_RAISE,
        ST_LOWER,
        ST_SEND
    } t_state;

    // wiper code as the fixed-width output field
    function automatic logic [CODE_OUT_W-1:0] to_code_out(input logic [WIPER_BITS-1:0] w);
        logic [WIPER_BITS+CODE_OUT_W-1:0] ext;
        ext = (WIPER_BITS+CODE_OUT_W)'(w);
        return ext[CODE_OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

[sv/dvt_ifs.sv]
// valid/ready channel interfaces for trim requests and serial bit results
`default_nettype none

interface dvt_req_if;
    logic                        valid;
    logic                        ready;
    logic [dvt_pkg::OPCODE_W-1:0] opcode;
    logic [dvt_pkg::VOLT_W-1:0]   target_volts;
    logic [dvt_pkg::VOLT_W-1:0]   setpoint_volts;
    logic [dvt_pkg::VOLT_W-1:0]   measured_volts;
    logic [dvt_pkg::VOLT_W-1:0]   reference_volts;
    logic [dvt_pkg::VOLT_W-1:0]   system_volts;

    modport source (
        output valid, opcode, target_volts, setpoint_volts,
               measured_volts, reference_volts, system_volts,
        input  ready
    );
    modport sink (
        input  valid, opcode, target_volts, setpoint_volts,
               measured_volts, reference_volts, system_volts,
        output ready
    );
endinterface

interface dvt_res_if;
    logic                          valid;
    logic                          ready;
    logic                          data_bit;
    logic [dvt_pkg::CODE_OUT_W-1:0] wiper_code;
    logic                          last_bit;

    modport source (
        output valid, data_bit, wiper_code, last_bit,
        input  ready
    );
    modport sink (
        input  valid, data_bit, wiper_code, last_bit,
        output ready
    );
endinterface

`default_nettype wire

[sv/digipot_voltage_trim_unit.sv]
// top level: digipot wiper set/trim sequencer with serial code output
`default_nettype none

// Digital potentiometer trim unit. One request is taken at a time; i_req.ready
// is high only while the unit is idle. A set request evaluates the cubic
// calibration polynomial in Horner form on one shared bit-serial multiplier
// (one bit of the target voltage per cycle, three steps). The coefficient
// fetch comes first, then each step loads, multiplies and accumulates, and
// clamp and window follow before the first output bit is offered. Raise
// and lower first update the wiper in their own state; resend offers the
// first bit in the cycle right after acceptance. Every request then
// delivers WIPER_BITS results, one per serial bit, most significant bit first,
// at one result per cycle while the sink is ready; last_bit marks the final
// one. After the last bit the unit returns to idle before it takes the next
// request.
// The eight coefficients live in a small ram behind the register port, with a
// valid flag per entry so that unwritten entries read as zero right after
// reset; there is no clearing pass. Register writes are meant for idle time.

module digipot_voltage_trim_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    dvt_req_if.sink                         i_req,
    dvt_res_if.source                       o_res,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [dvt_pkg::APB_AW-1:0] paddr,
    input  wire logic [dvt_pkg::APB_DW-1:0] pwdata,
    output logic      [dvt_pkg::APB_DW-1:0] prdata,
    output logic                            pready
);

    // ---------------------------------------------------------------
    // state
    // ---------------------------------------------------------------
    dvt_pkg::t_state    r_state, n_state;
    dvt_pkg::t_coef_idx r_cidx, n_cidx;

    logic                                   r_high, n_high;
    logic        [dvt_pkg::VOLT_W-1:0]      r_target, n_target;
    logic        [dvt_pkg::VOLT_W-1:0]      r_tsh, n_tsh;
    logic        [dvt_pkg::VOLT_W-1:0]      r_meas, n_meas;
    logic        [dvt_pkg::VOLT_W-1:0]      r_ref, n_ref;
    logic        [dvt_pkg::VOLT_W-1:0]      r_sys, n_sys;
    logic        [dvt_pkg::MUL_CNT_W-1:0]   r_mcnt, n_mcnt;
    logic signed [dvt_pkg::ACC_W-1:0]       r_acc, n_acc;
    logic signed [dvt_pkg::PROD_W-1:0]      r_mcand, n_mcand;
    logic signed [dvt_pkg::PROD_W-1:0]      r_prod, n_prod;

    logic        [dvt_pkg::WIPER_BITS-1:0]  r_wiper, n_wiper;
    logic        [dvt_pkg::WIPER_BITS-1:0]  r_win_min, n_win_min;
    logic        [dvt_pkg::WIN_BITS-1:0]    r_win_max, n_win_max;
    logic        [dvt_pkg::BIT_CNT_W-1:0]   r_bit, n_bit;

    // coefficient store
    logic        [dvt_pkg::NUM_COEF-1:0]    r_cvld;
    logic                                   r_vld_a, r_vld_b;
    logic                                   cfg_wr;
    logic        [dvt_pkg::COEF_AW-1:0]     cfg_addr;
    logic        [dvt_pkg::COEF_AW-1:0]     coef_raddr;
    logic        [dvt_pkg::COEF_W-1:0]      rdata_a, rdata_b;
    logic signed [dvt_pkg::COEF_W-1:0]      coef_b;

    // datapath terms
    logic signed [dvt_pkg::ACC_W-1:0]       acc_sum;
    logic signed [dvt_pkg::ACC_W-1:0]       acc_sat;
    logic signed [dvt_pkg::PROD_W-1:0]      prod_next;
    logic        [dvt_pkg::RATIO_W-1:0]     meas_scaled;
    logic        [dvt_pkg::RATIO_W-1:0]     ref_scaled;
    logic                                   out_low;
    logic        [dvt_pkg::BIT_CNT_W-1:0]   bit_idx;

    // ---------------------------------------------------------------
    // register port: write at the access phase, read data from the
    // address held since the setup phase
    // ---------------------------------------------------------------
    assign cfg_wr   = psel && penable && pwrite;
    assign cfg_addr = paddr[dvt_pkg::APB_AW-1:2];
    assign pready   = 1'b1;
    assign prdata   = r_vld_a ? rdata_a : '0;

    // coefficient of the selected set for the current horner step
    assign coef_raddr = {r_high, r_cidx};
    assign coef_b     = r_vld_b ? $signed(rdata_b) : '0;

    dvt_ram #(
        .WIDTH (dvt_pkg::COEF_W),
        .DEPTH (dvt_pkg::NUM_COEF)
    ) u_coef_ram (
        .i_clk     (i_clk),
        .i_we      (cfg_wr),
        .i_waddr   (cfg_addr),
        .i_wdata   (pwdata),
        .i_raddr_a (cfg_addr),
        .o_rdata_a (rdata_a),
        .i_raddr_b (coef_raddr),
        .o_rdata_b (rdata_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvld  <= '0;
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_cvld[cfg_addr] <= 1'b1;
            end
            r_vld_a <= r_cvld[cfg_addr];
            r_vld_b <= r_cvld[coef_raddr];
        end
    end

    // ---------------------------------------------------------------
    // shared arithmetic
    // ---------------------------------------------------------------
    // horner step result: floor(a*t/256) + c
    assign acc_sum = $signed(r_prod[dvt_pkg::PROD_W-1:dvt_pkg::PROD_SH])
                   + dvt_pkg::ACC_W'(coef_b);

    // clamp before the last multiply
    always_comb begin
        if (r_acc > dvt_pkg::ACC_LIMIT) begin
            acc_sat = dvt_pkg::ACC_LIMIT;
        end else if (r_acc < dvt_pkg::ACC_NEG) begin
            acc_sat = dvt_pkg::ACC_NEG;
        end else begin
            acc_sat = r_acc;
        end
    end

    // shift-add multiplier, target lsb first
    assign prod_next = r_tsh[0] ? r_prod + r_mcand : r_prod;

    // raise test
    assign meas_scaled = dvt_pkg::RATIO_W'(r_meas)
                       * dvt_pkg::RATIO_W'(dvt_pkg::RAISE_MUL_MEAS);
    assign ref_scaled  = dvt_pkg::RATIO_W'(r_ref)
                       * dvt_pkg::RATIO_W'(dvt_pkg::RAISE_MUL_REF);
    assign out_low     = (r_ref != '0) ? (meas_scaled < ref_scaled) : (r_meas < r_sys);

    // serial output, msb first
    assign bit_idx          = dvt_pkg::BIT_CNT_W'(dvt_pkg::WIPER_BITS - 1) - r_bit;
    assign o_res.data_bit   = r_wiper[bit_idx];
    assign o_res.wiper_code = dvt_pkg::to_code_out(r_wiper);
    assign o_res.last_bit   = (r_bit == dvt_pkg::BIT_CNT_W'(dvt_pkg::WIPER_BITS - 1));

    // ---------------------------------------------------------------
    // state register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dvt_pkg::ST_IDLE;
            r_cidx    <= dvt_pkg::CI_CUBIC;
            r_mcnt    <= '0;
            r_bit     <= '0;
            r_wiper   <= '0;
            r_win_min <= '0;
            r_win_max <= '0;
        end else begin
            r_state   <= n_state;
            r_cidx    <= n_cidx;
            r_mcnt    <= n_mcnt;
            r_bit     <= n_bit;
            r_wiper   <= n_wiper;
            r_win_min <= n_win_min;
            r_win_max <= n_win_max;
        end
    end

    // request payload and arithmetic registers
    always_ff @(posedge i_clk) begin
        r_high   <= n_high;
        r_target <= n_target;
        r_tsh    <= n_tsh;
        r_meas   <= n_meas;
        r_ref    <= n_ref;
        r_sys    <= n_sys;
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_prod   <= n_prod;
    end

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb begin
        logic [dvt_pkg::WIPER_BITS-1:0] w_dec;

        n_state   = r_state;
        n_cidx    = r_cidx;
        n_high    = r_high;
        n_target  = r_target;
        n_tsh     = r_tsh;
        n_meas    = r_meas;
        n_ref     = r_ref;
        n_sys     = r_sys;
        n_mcnt    = r_mcnt;
        n_acc     = r_acc;
        n_mcand   = r_mcand;
        n_prod    = r_prod;
        n_wiper   = r_wiper;
        n_win_min = r_win_min;
        n_win_max = r_win_max;
        n_bit     = r_bit;
        w_dec     = r_wiper;

        i_req.ready = 1'b0;
        o_res.valid = 1'b0;

        case (r_state)
            dvt_pkg::ST_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_high   = (i_req.setpoint_volts
                                >= dvt_pkg::VOLT_W'(dvt_pkg::SETPOINT_SPLIT));
                    n_target = i_req.target_volts;
                    n_meas   = i_req.measured_volts;
                    n_ref    = i_req.reference_volts;
                    n_sys    = i_req.system_volts;
                    n_cidx   = dvt_pkg::CI_CUBIC;
                    n_bit    = '0;
                    case (dvt_pkg::t_opcode'(i_req.opcode))
                        dvt_pkg::OP_SET:    n_state = dvt_pkg::ST_FETCH;
                        dvt_pkg::OP_RAISE:  n_state = dvt_pkg::ST_RAISE;
                        dvt_pkg::OP_LOWER:  n_state = dvt_pkg::ST_LOWER;
                        dvt_pkg::OP_RESEND: n_state = dvt_pkg::ST_SEND;
                        default:            n_state = dvt_pkg::ST_SEND;
                    endcase
                end
            end

            // ram read of the cubic term in flight
            dvt_pkg::ST_FETCH: begin
                n_state = dvt_pkg::ST_INIT;
            end

            dvt_pkg::ST_INIT: begin
                n_acc   = dvt_pkg::ACC_W'(coef_b);
                n_cidx  = dvt_pkg::CI_SQUARE;
                n_state = dvt_pkg::ST_PREP;
            end

            // load multiplicand, saturated before the offset step
            dvt_pkg::ST_PREP: begin
                n_mcand = (r_cidx == dvt_pkg::CI_OFFSET) ? dvt_pkg::PROD_W'(acc_sat)
                                                         : dvt_pkg::PROD_W'(r_acc);
                n_prod  = '0;
                n_tsh   = r_target;
                n_mcnt  = '0;
                n_state = dvt_pkg::ST_MUL;
            end

            dvt_pkg::ST_MUL: begin
                n_prod  = prod_next;
                n_mcand = r_mcand <<< 1;
                n_tsh   = r_tsh >> 1;
                n_mcnt  = r_mcnt + dvt_pkg::MUL_CNT_W'(1);
                if (r_mcnt == dvt_pkg::MUL_CNT_W'(dvt_pkg::VOLT_W - 1)) begin
                    n_state = dvt_pkg::ST_ACC;
                end
            end

            dvt_pkg::ST_ACC: begin
                n_acc = acc_sum;
                if (r_cidx == dvt_pkg::CI_OFFSET) begin
                    n_state = dvt_pkg::ST_CODE;
                end else begin
                    n_cidx  = dvt_pkg::t_coef_idx'(r_cidx + 2'd1);
                    n_state = dvt_pkg::ST_PREP;
                end
            end

            // clamp polynomial to 1..max code
            dvt_pkg::ST_CODE: begin
                if (r_acc >= dvt_pkg::CODE_TOP) begin
                    n_wiper = dvt_pkg::WIPER_BITS'(dvt_pkg::WIPER_MAX);
                end else if (r_acc < dvt_pkg::CODE_ONE) begin
                    n_wiper = dvt_pkg::WIPER_BITS'(1);
                end else begin
                    n_wiper = r_acc[dvt_pkg::FRAC_BITS +: dvt_pkg::WIPER_BITS];
                end
                n_state = dvt_pkg::ST_WIN;
            end

            // trim window around the new code
            dvt_pkg::ST_WIN: begin
                if (int'(r_wiper) > dvt_pkg::TRIM_WINDOW) begin
                    n_win_min = dvt_pkg::WIPER_BITS'(int'(r_wiper) - dvt_pkg::TRIM_WINDOW);
                end else begin
                    n_win_min = dvt_pkg::WIPER_BITS'(1);
                end
                if ((dvt_pkg::TRIM_WINDOW > dvt_pkg::WIPER_MAX) ||
                    (int'(r_wiper) < dvt_pkg::WIPER_MAX - dvt_pkg::TRIM_WINDOW)) begin
                    n_win_max = dvt_pkg::WIN_BITS'(int'(r_wiper) + dvt_pkg::TRIM_WINDOW);
                end else begin
                    n_win_max = dvt_pkg::WIN_BITS'(dvt_pkg::WIPER_MAX);
                end
                n_state = dvt_pkg::ST_SEND;
            end

            // step down while output is low, keep within window and above zero
            dvt_pkg::ST_RAISE: begin
                w_dec = out_low ? r_wiper - dvt_pkg::WIPER_BITS'(1) : r_wiper;
                if (w_dec < r_win_min) begin
                    w_dec = r_win_min;
                end
                if (w_dec == '0) begin
                    w_dec = dvt_pkg::WIPER_BITS'(1);
                end
                n_wiper = w_dec;
                n_state = dvt_pkg::ST_SEND;
            end

            dvt_pkg::ST_LOWER: begin
                if (dvt_pkg::WIN_BITS'(r_wiper) < r_win_max) begin
                    n_wiper = r_wiper + dvt_pkg::WIPER_BITS'(1);
                end
                n_state = dvt_pkg::ST_SEND;
            end

            dvt_pkg::ST_SEND: begin
                o_res.valid = 1'b1;
                if (o_res.ready) begin
                    if (o_res.last_bit) begin
                        n_bit   = '0;
                        n_state = dvt_pkg::ST_IDLE;
                    end else begin
                        n_bit = r_bit + dvt_pkg::BIT_CNT_W'(1);
                    end
                end
            end

            default: begin
                n_state = dvt_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    // no request taken while bits are still going out
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !o_res.valid)
        else $error("request accepted while results pending");

    // clamped code is never zero
    a_code_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dvt_pkg::ST_WIN) |-> (r_wiper != '0))
        else $error("set produced a zero wiper code");

    // window stays ordered after a set
    a_win_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dvt_pkg::ST_WIN) |=> (dvt_pkg::WIN_BITS'(r_win_min) <= r_win_max))
        else $error("trim window inverted");

    // raise never leaves the wiper at zero
    a_raise_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dvt_pkg::ST_RAISE) |=> (r_wiper != '0))
        else $error("raise left wiper at zero");

endmodule

`default_nettype wire

[sv/dvt_ram.sv]
// generic ram: one write port, two registered read ports
`default_nettype none

module dvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic      [WIDTH-1:0]         o_rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire
